// ===== rtl/pse_pkg.sv =====
// Package for the stored-block PNG encoder: queue entry type, sizes and the CRC-32 byte step.
// Used by every module in the rtl folder; depends on nothing.
`default_nettype none
package pse_pkg;

  localparam int DimW       = 14;
  localparam int MaxDim     = 8192;
  localparam int RawW       = 28;
  localparam int QDepth     = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;
  localparam logic [31:0] CrcPoly  = 32'hEDB88320;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [16:0] BlkLimit = 17'd65535;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  // One accepted image byte and what it implies for the output stream.
  typedef struct packed {
    logic [7:0]      data;
    logic            hdr;
    logic            filt;
    logic            last;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pse_queue.sv =====
// Four-entry job queue between the classifying front end and the byte sequencer.
// Depends on pse_pkg.
`default_nettype none
module pse_queue
  import pse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCntW'(push) - QCntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pse_front.sv =====
// Front end: configuration registers, row and image tracking, job classification.
// Depends on pse_pkg.
`default_nettype none
module pse_front
  import pse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [DimW-1:0] cfg_data,
  input  wire logic            image_valid,
  output logic                 image_ready,
  input  wire logic [7:0]      image_byte,
  input  wire logic            q_full,
  output logic                 push,
  output job_t                 push_job
);

  logic [DimW-1:0] image_width, image_height, lat_w, lat_h;
  logic            header_sent;
  logic [14:0]     byte_in_row;
  logic [DimW-1:0] row_index;
  logic [DimW-1:0] w_eff, h_eff;
  logic [14:0]     row_len;
  logic            end_row;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxDim)) return DimW'(MaxDim);
    return v;
  endfunction

  assign image_ready = !q_full;
  assign push        = image_valid && !q_full;

  always_comb begin
    w_eff   = header_sent ? lat_w : clamp_dim(image_width);
    h_eff   = header_sent ? lat_h : clamp_dim(image_height);
    row_len = {w_eff, 1'b0} + {1'b0, w_eff};
    end_row = (byte_in_row + 15'd1) >= row_len;
    push_job.data = image_byte;
    push_job.hdr  = !header_sent;
    push_job.filt = (byte_in_row == '0);
    push_job.last = end_row && (({1'b0, row_index} + 15'd1) >= {1'b0, h_eff});
    push_job.w    = w_eff;
    push_job.h    = h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DimW'(1);
      image_height <= DimW'(1);
      lat_w        <= DimW'(1);
      lat_h        <= DimW'(1);
      header_sent  <= 1'b0;
      byte_in_row  <= '0;
      row_index    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgWidth) image_width <= cfg_data;
        else                       image_height <= cfg_data;
      end
      if (push) begin
        lat_w <= w_eff;
        lat_h <= h_eff;
        if (push_job.last) begin
          header_sent <= 1'b0;
          byte_in_row <= '0;
          row_index   <= '0;
        end else begin
          header_sent <= 1'b1;
          if (end_row) begin
            byte_in_row <= '0;
            row_index   <= row_index + 1'b1;
          end else begin
            byte_in_row <= byte_in_row + 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pse_back.sv =====
// Back end: byte sequencer for headers, stored-block headers, data and trailer,
// with running CRC-32 and Adler-32 and the output register. Depends on pse_pkg.
`default_nettype none
module pse_back
  import pse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire job_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic      end_of_run,
  output logic      end_of_file
);

  typedef enum logic [1:0] {ST_START, ST_HDR, ST_RAW, ST_TRL} state_t;

  localparam logic [5:0] HdrLast = 6'd42;
  localparam logic [4:0] TrlLast = 5'd19;

  state_t      state, cur;
  logic [5:0]  cnt;
  logic [2:0]  bcnt;
  logic        raw_filt, cur_filt;
  logic [31:0] crc;
  logic [15:0] adler_low, adler_high;
  logic [15:0] blk_left;
  logic [RawW-1:0] raw_left;

  logic [RawW-1:0] raw_total;
  logic [11:0]     q0;
  logic [16:0]     r0;
  logic [12:0]     nblk;
  logic [31:0]     idat_len;

  logic        advance, in_blk, feed, crc_rst;
  logic [7:0]  byte_val;
  logic        eor, eof;
  logic [15:0] blk_n;
  logic        bfinal;
  logic [16:0] lo_sum, hi_sum, lo_new, hi_new;
  logic [31:0] crc_out;

  // Size pipeline: raw_total, q0, r0, nblk and idat_len are registered in that order from the job at the head.
  always_ff @(posedge clk) begin
    logic [12:0] q;
    logic [16:0] r;
    raw_total <= RawW'({1'b0, head.w, 1'b0} + {2'b0, head.w} + 16'd1) * RawW'(head.h);
    q0 <= raw_total[RawW-1:16];
    r0 <= {1'b0, raw_total[15:0]} + {5'd0, q0};
    q  = {1'b0, q0};
    r  = r0;
    if (r0 >= BlkLimit) begin
      q = q + 13'd1;
      r = r0 - BlkLimit;
    end
    nblk     <= q + 13'(r != '0);
    idat_len <= {4'd0, raw_total} + 32'(nblk) * 32'd5 + 32'd6;
  end

  assign crc_out = ~crc;
  assign bfinal  = ({1'b0, raw_left} <= {12'd0, BlkLimit});
  assign blk_n   = bfinal ? raw_left[15:0] : BlkLimit[15:0];

  always_comb begin
    lo_sum = {1'b0, adler_low} + {9'd0, byte_val};
    lo_new = (lo_sum >= AdlerMod) ? lo_sum - AdlerMod : lo_sum;
    hi_sum = {1'b0, adler_high} + lo_new;
    hi_new = (hi_sum >= AdlerMod) ? hi_sum - AdlerMod : hi_sum;
  end

  always_comb begin
    cur      = state;
    cur_filt = raw_filt;
    if (state == ST_START) begin
      cur      = head.hdr ? ST_HDR : ST_RAW;
      cur_filt = head.filt;
    end
    in_blk   = (cur == ST_RAW) && (blk_left == '0);
    advance  = head_valid && (!out_valid || out_ready);
    byte_val = 8'd0;
    feed     = 1'b0;
    crc_rst  = 1'b0;
    eor      = 1'b0;
    eof      = 1'b0;
    case (cur)
      ST_HDR: begin
        feed = (cnt >= 6'd12 && cnt <= 6'd28) || (cnt >= 6'd37);
        crc_rst = (cnt == 6'd12) || (cnt == 6'd37);
        case (cnt)
          6'd0: byte_val = 8'd137;  6'd1: byte_val = 8'd80;
          6'd2: byte_val = 8'd78;   6'd3: byte_val = 8'd71;
          6'd4: byte_val = 8'd13;   6'd5: byte_val = 8'd10;
          6'd6: byte_val = 8'd26;   6'd7: byte_val = 8'd10;
          6'd11: byte_val = 8'd13;
          6'd12: byte_val = 8'h49;  6'd13: byte_val = 8'h48;
          6'd14: byte_val = 8'h44;  6'd15: byte_val = 8'h52;
          6'd18: byte_val = {2'd0, head.w[13:8]};
          6'd19: byte_val = head.w[7:0];
          6'd22: byte_val = {2'd0, head.h[13:8]};
          6'd23: byte_val = head.h[7:0];
          6'd24: byte_val = 8'd8;   6'd25: byte_val = 8'd2;
          6'd29: byte_val = crc_out[31:24]; 6'd30: byte_val = crc_out[23:16];
          6'd31: byte_val = crc_out[15:8];  6'd32: byte_val = crc_out[7:0];
          6'd33: byte_val = idat_len[31:24]; 6'd34: byte_val = idat_len[23:16];
          6'd35: byte_val = idat_len[15:8];  6'd36: byte_val = idat_len[7:0];
          6'd37: byte_val = 8'h49;  6'd38: byte_val = 8'h44;
          6'd39: byte_val = 8'h41;  6'd40: byte_val = 8'h54;
          6'd41: byte_val = 8'h78;  6'd42: byte_val = 8'h01;
          default: byte_val = 8'd0;
        endcase
      end
      ST_RAW: begin
        feed = 1'b1;
        if (in_blk) begin
          case (bcnt)
            3'd0: byte_val = {7'd0, bfinal};
            3'd1: byte_val = blk_n[7:0];
            3'd2: byte_val = blk_n[15:8];
            3'd3: byte_val = ~blk_n[7:0];
            default: byte_val = ~blk_n[15:8];
          endcase
        end else begin
          byte_val = cur_filt ? 8'd0 : head.data;
          eor = !cur_filt && !head.last;
        end
      end
      ST_TRL: begin
        feed = (cnt <= 6'd3) || (cnt >= 6'd12 && cnt <= 6'd15);
        crc_rst = (cnt == 6'd12);
        eor = (cnt == 6'(TrlLast));
        eof = eor;
        case (cnt[4:0])
          5'd0: byte_val = adler_high[15:8]; 5'd1: byte_val = adler_high[7:0];
          5'd2: byte_val = adler_low[15:8];  5'd3: byte_val = adler_low[7:0];
          5'd4, 5'd16: byte_val = crc_out[31:24];
          5'd5, 5'd17: byte_val = crc_out[23:16];
          5'd6, 5'd18: byte_val = crc_out[15:8];
          5'd7, 5'd19: byte_val = crc_out[7:0];
          5'd12: byte_val = 8'h49; 5'd13: byte_val = 8'h45;
          5'd14: byte_val = 8'h4E; 5'd15: byte_val = 8'h44;
          default: byte_val = 8'd0;
        endcase
      end
      default: byte_val = 8'd0;
    endcase
    pop = advance && eor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      cnt        <= '0;
      bcnt       <= '0;
      raw_filt   <= 1'b0;
      crc        <= '1;
      adler_low  <= 16'd1;
      adler_high <= '0;
      blk_left   <= '0;
      raw_left   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid   <= 1'b1;
        out_byte    <= byte_val;
        end_of_run  <= eor;
        end_of_file <= eof;
        if (feed) crc <= crc_byte(crc_rst ? '1 : crc, byte_val);
        case (cur)
          ST_HDR: begin
            if (cnt == HdrLast) begin
              state    <= ST_RAW;
              raw_filt <= head.filt;
              raw_left <= raw_total;
              blk_left <= '0;
              cnt      <= '0;
            end else begin
              state <= ST_HDR;
              cnt   <= cnt + 1'b1;
            end
          end
          ST_RAW: begin
            if (in_blk) begin
              state    <= ST_RAW;
              raw_filt <= cur_filt;
              if (bcnt == 3'd4) begin
                bcnt     <= '0;
                blk_left <= blk_n;
              end else begin
                bcnt <= bcnt + 1'b1;
              end
            end else begin
              adler_low  <= lo_new[15:0];
              adler_high <= hi_new[15:0];
              blk_left   <= blk_left - 1'b1;
              raw_left   <= raw_left - 1'b1;
              if (cur_filt) begin
                state    <= ST_RAW;
                raw_filt <= 1'b0;
              end else if (head.last) begin
                state <= ST_TRL;
                cnt   <= '0;
              end else begin
                state <= ST_START;
              end
            end
          end
          ST_TRL: begin
            if (eof) begin
              state      <= ST_START;
              cnt        <= '0;
              crc        <= '1;
              adler_low  <= 16'd1;
              adler_high <= '0;
              blk_left   <= '0;
              raw_left   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          default: state <= ST_START;
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/png_stored_rgb_encoder_top.sv =====
// Top level of the stored-block PNG encoder: joins front end, job queue and byte sequencer.
// Depends on pse_pkg, pse_front, pse_queue and pse_back.
//
// The encoder turns a stream of raw RGB bytes (R, G, B per pixel, top row first) into a
// complete uncompressed PNG file, one output byte per clock cycle at best. Set image_width
// and image_height through the write port while the block is idle; they are sampled at
// the first byte of each image, with zero acting as one and values above 8192 as 8192.
// Every input transaction produces one or more output transactions, and end_of_run marks
// the last of them. The first byte of an image adds 43 extra output bytes for the signature,
// IHDR chunk, IDAT length and tag and zlib header; the first byte of each row adds one
// extra byte for the filter byte; a new stored block adds five bytes for its header;
// the last byte adds twenty bytes for the Adler-32, IDAT CRC and IEND chunk, the last of
// which carries end_of_file. Otherwise a byte yields just one output byte. The output
// sequencer, which emits at most one byte per cycle, sets the rate; a four-entry queue lets
// input keep flowing while a burst is being sent, and the output register holds each byte
// until it is taken and is refilled in the cycle it is taken.
`default_nettype none
module png_stored_rgb_encoder_top
  import pse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [DimW-1:0] cfg_data,
  input  wire logic            image_valid,
  output logic                 image_ready,
  input  wire logic [7:0]      image_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 end_of_run,
  output logic                 end_of_file
);

  // Jobs handed from the front end to the queue.
  logic push;
  job_t push_job;
  logic q_full;
  // Head of the queue as seen by the sequencer.
  logic head_valid;
  job_t head;
  logic pop;

  pse_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .image_valid(image_valid), .image_ready(image_ready), .image_byte(image_byte),
    .q_full(q_full), .push(push), .push_job(push_job)
  );

  pse_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_job(push_job), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  pse_back u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .end_of_run(end_of_run), .end_of_file(end_of_file)
  );

  // The final byte of a file always closes the run of its input transaction.
  a_eof_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_file |-> end_of_run)
    else $error("end_of_file without end_of_run");

  // A job leaves the queue only when it is present.
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // Nothing is pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

endmodule
`default_nettype wire
